// ===== design/tpw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch point transform package
// Payload, configuration and status types shared by the touch point
// transform and release watchdog block, together with its fixed codes.
// ----------------------------------------------------------------------------
package tpw_pkg;

   localparam int CoordWidth = 16;
   localparam int SlotWidth  = 4;
   localparam int TicksWidth = 24;
   localparam int CsrDataWidth = 24;

   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [1:0] POINT_ACTIVE = 2'd2;

   localparam logic [3:0] ROT_90  = 4'd2;
   localparam logic [3:0] ROT_180 = 4'd4;
   localparam logic [3:0] ROT_270 = 4'd8;

   localparam int MaskReflectX = 4;
   localparam int MaskReflectY = 5;

   typedef enum logic [2:0] {
      REG_PANEL_WIDTH       = 3'd0,
      REG_PANEL_HEIGHT      = 3'd1,
      REG_SWAP_AXES         = 3'd2,
      REG_INVERT_HORIZONTAL = 3'd3,
      REG_INVERT_VERTICAL   = 3'd4,
      REG_ROTATION_MASK     = 3'd5,
      REG_WATCHDOG_TICKS    = 3'd6,
      REG_WAKE_ALLOWED      = 3'd7
   } tpw_reg_type;

   localparam logic [CoordWidth-1:0] PANEL_WIDTH_RESET    = 16'd480;
   localparam logic [CoordWidth-1:0] PANEL_HEIGHT_RESET   = 16'd480;
   localparam logic [5:0]            ROTATION_MASK_RESET  = 6'd1;
   localparam logic [TicksWidth-1:0] WATCHDOG_TICKS_RESET = 24'd100;

   typedef struct packed {
      logic                  op;
      logic [SlotWidth-1:0]  first_slot;
      logic [1:0]            first_state;
      logic [CoordWidth-1:0] first_x;
      logic [CoordWidth-1:0] first_y;
      logic [SlotWidth-1:0]  second_slot;
      logic [1:0]            second_state;
      logic [CoordWidth-1:0] second_x;
      logic [CoordWidth-1:0] second_y;
   } tpw_req_type;

   typedef struct packed {
      logic                  first_reported;
      logic [SlotWidth-1:0]  first_out_slot;
      logic                  first_active;
      logic [CoordWidth-1:0] first_out_x;
      logic [CoordWidth-1:0] first_out_y;
      logic                  second_reported;
      logic [SlotWidth-1:0]  second_out_slot;
      logic                  second_active;
      logic [CoordWidth-1:0] second_out_x;
      logic [CoordWidth-1:0] second_out_y;
      logic                  release_all;
      logic                  wake_request;
   } tpw_rsp_type;

   typedef struct packed {
      tpw_reg_type             index;
      logic [CsrDataWidth-1:0] data;
   } tpw_csr_type;

   typedef struct packed {
      logic [CoordWidth-1:0] panel_width;
      logic [CoordWidth-1:0] panel_height;
      logic                  swap_axes;
      logic                  invert_horizontal;
      logic                  invert_vertical;
      logic [5:0]            rotation_mask;
      logic [TicksWidth-1:0] watchdog_ticks;
      logic                  wake_allowed;
   } tpw_cfg_type;

   typedef struct packed {
      logic                  reported;
      logic [SlotWidth-1:0]  slot;
      logic                  active;
      logic [CoordWidth-1:0] x;
      logic [CoordWidth-1:0] y;
   } tpw_point_type;

   typedef struct packed {
      logic has_result;
      logic release_all;
      logic wake;
   } tpw_status_type;

endpackage

// ===== design/tpw_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch point transform channel
// Valid and ready handshake channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface tpw_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/tpw_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch point transform configuration registers
// Holds the eight configuration registers and takes one write per cycle.
// ----------------------------------------------------------------------------
module tpw_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  tpw_pkg::tpw_csr_type wr,
   output tpw_pkg::tpw_cfg_type cfg
);
   import tpw_pkg::*;

   tpw_cfg_type cfg_ff;
   tpw_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr.index)
            REG_PANEL_WIDTH:       cfg_in.panel_width       = wr.data[CoordWidth-1:0];
            REG_PANEL_HEIGHT:      cfg_in.panel_height      = wr.data[CoordWidth-1:0];
            REG_SWAP_AXES:         cfg_in.swap_axes         = wr.data[0];
            REG_INVERT_HORIZONTAL: cfg_in.invert_horizontal = wr.data[0];
            REG_INVERT_VERTICAL:   cfg_in.invert_vertical   = wr.data[0];
            REG_ROTATION_MASK:     cfg_in.rotation_mask     = wr.data[5:0];
            REG_WATCHDOG_TICKS:    cfg_in.watchdog_ticks    = wr.data[TicksWidth-1:0];
            REG_WAKE_ALLOWED:      cfg_in.wake_allowed      = wr.data[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.panel_width       <= PANEL_WIDTH_RESET;
         cfg_ff.panel_height      <= PANEL_HEIGHT_RESET;
         cfg_ff.swap_axes         <= 1'b0;
         cfg_ff.invert_horizontal <= 1'b0;
         cfg_ff.invert_vertical   <= 1'b0;
         cfg_ff.rotation_mask     <= ROTATION_MASK_RESET;
         cfg_ff.watchdog_ticks    <= WATCHDOG_TICKS_RESET;
         cfg_ff.wake_allowed      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/tpw_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch point transform for one point
// Slot check, axis swap, panel inversion and rotation with reflection.
// ----------------------------------------------------------------------------
module tpw_point #(
   parameter int SLOT_COUNT = 2
) (
   input  tpw_pkg::tpw_cfg_type             cfg,
   input  logic [tpw_pkg::SlotWidth-1:0]    slot,
   input  logic [1:0]                       state,
   input  logic [tpw_pkg::CoordWidth-1:0]   raw_x,
   input  logic [tpw_pkg::CoordWidth-1:0]   raw_y,
   output tpw_pkg::tpw_point_type           point
);
   import tpw_pkg::*;

   logic [CoordWidth-1:0] w1;
   logic [CoordWidth-1:0] h1;
   logic [CoordWidth-1:0] sx;
   logic [CoordWidth-1:0] sy;
   logic [CoordWidth-1:0] ix;
   logic [CoordWidth-1:0] iy;
   logic [CoordWidth-1:0] nx;
   logic [CoordWidth-1:0] ny;
   logic [CoordWidth-1:0] rx;
   logic [CoordWidth-1:0] ry;
   logic                  in_range;
   logic                  active;

   assign w1 = cfg.panel_width - 16'd1;
   assign h1 = cfg.panel_height - 16'd1;

   assign sx = cfg.swap_axes ? raw_y : raw_x;
   assign sy = cfg.swap_axes ? raw_x : raw_y;
   assign ix = cfg.invert_horizontal ? (w1 - sx) : sx;
   assign iy = cfg.invert_vertical ? (h1 - sy) : sy;

   assign nx = cfg.rotation_mask[MaskReflectX] ? (w1 - ix) : ix;
   assign ny = cfg.rotation_mask[MaskReflectY] ? (h1 - iy) : iy;

   always_comb begin
      case (cfg.rotation_mask[3:0])
         ROT_90: begin
            rx = ny;
            ry = w1 - nx;
         end
         ROT_180: begin
            rx = w1 - nx;
            ry = h1 - ny;
         end
         ROT_270: begin
            rx = h1 - ny;
            ry = nx;
         end
         default: begin
            rx = nx;
            ry = ny;
         end
      endcase
   end

   assign in_range = (slot < SlotWidth'(SLOT_COUNT));
   assign active   = in_range && (state == POINT_ACTIVE);

   always_comb begin
      point = '0;
      if (in_range) begin
         point.reported = 1'b1;
         point.slot     = slot;
         point.active   = active;
         if (active) begin
            point.x = rx;
            point.y = ry;
         end
      end
   end

endmodule

// ===== design/tpw_watchdog.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch point release watchdog
// Held-finger flag and release countdown, and the kind of result an item gives.
// ----------------------------------------------------------------------------
module tpw_watchdog (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic                    op,
   input  logic                    touch_active,
   input  tpw_pkg::tpw_cfg_type    cfg,
   output tpw_pkg::tpw_status_type status
);
   import tpw_pkg::*;

   logic                  finger_held_ff;
   logic                  finger_held_in;
   logic [TicksWidth-1:0] countdown_ff;
   logic [TicksWidth-1:0] countdown_in;
   logic [TicksWidth-1:0] countdown_dec;

   assign countdown_dec = countdown_ff - 24'd1;

   always_comb begin
      status         = '0;
      finger_held_in = finger_held_ff;
      countdown_in   = countdown_ff;
      if (op == OP_TICK) begin
         if (countdown_ff != '0) begin
            countdown_in = countdown_dec;
            if (countdown_dec == '0) begin
               finger_held_in     = 1'b0;
               status.has_result  = 1'b1;
               status.release_all = 1'b1;
            end
         end
      end else begin
         status.has_result = 1'b1;
         status.wake       = touch_active & cfg.wake_allowed;
         if (touch_active) begin
            finger_held_in = 1'b1;
            countdown_in   = (cfg.watchdog_ticks != '0) ? cfg.watchdog_ticks : 24'd1;
         end else if (finger_held_ff) begin
            finger_held_in = 1'b0;
            countdown_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finger_held_ff <= 1'b0;
         countdown_ff   <= '0;
      end else if (fire) begin
         finger_held_ff <= finger_held_in;
         countdown_ff   <= countdown_in;
      end
   end

`ifndef SYNTHESIS
   a_armed_means_held: assert property (@(posedge clock) disable iff (reset)
      (countdown_ff != '0) |-> finger_held_ff)
      else $error("watchdog armed without a held finger");

   a_release_on_last_tick: assert property (@(posedge clock) disable iff (reset)
      (fire && status.release_all) |-> (countdown_ff == 24'd1))
      else $error("release given before the countdown ran out");

   a_active_arms: assert property (@(posedge clock) disable iff (reset)
      (fire && (op == OP_REPORT) && touch_active) |=> (countdown_ff != '0))
      else $error("active report did not arm the watchdog");
`endif

endmodule

// ===== design/touch_point_transform_watchdog_unit.sv =====
`timescale 1ns / 1ps
// A request is held in the input register and its result in the result register,
// from which it is taken. Throughput: one request per cycle unless results back up;
// a tick gives a result only when it runs the countdown out and releases.
// Reset clears both registers' valid flags and the watchdog, and loads the
// configuration defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
// Touch point transform and release watchdog
// Transforms the two points of a touch report and releases held fingers
// when the tick count after the last active report runs out.
// ----------------------------------------------------------------------------
module touch_point_transform_watchdog_unit #(
   parameter int SLOT_COUNT = 2
) (
   input logic clock,
   input logic reset,
   tpw_chan_if.sink   req_chan,
   tpw_chan_if.source rsp_chan,
   tpw_chan_if.sink   csr_chan
);
   import tpw_pkg::*;

   tpw_cfg_type    cfg;
   tpw_status_type status;
   tpw_point_type  first_point;
   tpw_point_type  second_point;

   tpw_req_type req_ff;
   logic        req_valid_ff;
   logic        req_valid_in;
   tpw_rsp_type rsp_ff;
   tpw_rsp_type rsp_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        req_accept;
   logic        advance;
   logic        fire;

   assign csr_chan.ready = 1'b1;

   tpw_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_chan.valid),
      .wr    (csr_chan.payload),
      .cfg   (cfg)
   );

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_valid_ff && advance;
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_valid_in   = req_accept || (req_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_chan.payload;
      end
   end

   tpw_point #(.SLOT_COUNT(SLOT_COUNT)) u_first (
      .cfg   (cfg),
      .slot  (req_ff.first_slot),
      .state (req_ff.first_state),
      .raw_x (req_ff.first_x),
      .raw_y (req_ff.first_y),
      .point (first_point)
   );

   tpw_point #(.SLOT_COUNT(SLOT_COUNT)) u_second (
      .cfg   (cfg),
      .slot  (req_ff.second_slot),
      .state (req_ff.second_state),
      .raw_x (req_ff.second_x),
      .raw_y (req_ff.second_y),
      .point (second_point)
   );

   tpw_watchdog u_watchdog (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .op           (req_ff.op),
      .touch_active (first_point.active || second_point.active),
      .cfg          (cfg),
      .status       (status)
   );

   always_comb begin
      rsp_in = '0;
      if (req_ff.op == OP_REPORT) begin
         rsp_in.first_reported  = first_point.reported;
         rsp_in.first_out_slot  = first_point.slot;
         rsp_in.first_active    = first_point.active;
         rsp_in.first_out_x     = first_point.x;
         rsp_in.first_out_y     = first_point.y;
         rsp_in.second_reported = second_point.reported;
         rsp_in.second_out_slot = second_point.slot;
         rsp_in.second_active   = second_point.active;
         rsp_in.second_out_x    = second_point.x;
         rsp_in.second_out_y    = second_point.y;
         rsp_in.wake_request    = status.wake;
      end else begin
         rsp_in.release_all = status.release_all;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (fire) begin
         rsp_valid_in = status.has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

`ifndef SYNTHESIS
   a_release_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.release_all) |->
         (!rsp_ff.first_reported && !rsp_ff.second_reported && !rsp_ff.wake_request))
      else $error("release result carries point data");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (req_valid_ff && rsp_valid_ff && !rsp_chan.ready))
      else $error("request refused while the pipeline can move");
`endif

endmodule

// ===== tb/touch_point_transform_watchdog_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch point transform and release watchdog unit test
// Drives touch reports and time ticks into the unit under random idling on
// both sides. Each accepted request is run through a local predictor of the
// point transform and the watchdog, and every result is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module touch_point_transform_watchdog_unit_test;
   import tpw_pkg::*;

   localparam int SlotCount     = 2;
   localparam int ResultLatency = 2;
   localparam int StallLimit    = 2000;
   localparam int MismatchShown = 10;

   localparam logic [1:0] POINT_START   = 2'd0;
   localparam logic [1:0] POINT_RELEASE = 2'd1;
   localparam logic [1:0] POINT_UNUSED  = 2'd3;

   localparam logic [3:0] ROT_NONE = 4'd0;
   localparam logic [3:0] ROT_0    = 4'd1;

   logic clock;
   logic reset;

   tpw_chan_if #(.payload_type(tpw_req_type)) req_if ();
   tpw_chan_if #(.payload_type(tpw_rsp_type)) rsp_if ();
   tpw_chan_if #(.payload_type(tpw_csr_type)) csr_if ();

   touch_point_transform_watchdog_unit #(
      .SLOT_COUNT(SlotCount)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   tpw_cfg_type           panel_cfg;
   logic                  held_finger;
   logic [TicksWidth-1:0] release_ticks_left;
   tpw_rsp_type           due_touch_results [$];
   tpw_rsp_type           oldest_due;

   int unsigned mismatch_count;
   int unsigned quiet_cycles;
   int unsigned rsp_hold_off;
   int unsigned rsp_stall_left;
   bit          req_gaps_on;
   bit          rsp_gaps_on;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [CoordWidth-1:0] mirror(input logic [CoordWidth-1:0] size,
                                                    input logic [CoordWidth-1:0] v);
      return size - 16'd1 - v;
   endfunction

   function automatic tpw_point_type transform_point(input logic [SlotWidth-1:0] slot,
                                                     input logic [1:0] state,
                                                     input logic [CoordWidth-1:0] x_raw,
                                                     input logic [CoordWidth-1:0] y_raw,
                                                     output bit touching);
      tpw_point_type         p;
      logic [CoordWidth-1:0] x, y, t, nx, ny;
      p = '0;
      touching = 1'b0;
      if (slot >= SlotCount) return p;
      x = x_raw;
      y = y_raw;
      if (panel_cfg.swap_axes) begin
         t = x;
         x = y;
         y = t;
      end
      if (panel_cfg.invert_horizontal) x = mirror(panel_cfg.panel_width, x);
      if (panel_cfg.invert_vertical) y = mirror(panel_cfg.panel_height, y);
      touching = (state == POINT_ACTIVE);
      p.reported = 1'b1;
      p.slot = slot;
      p.active = touching;
      if (touching) begin
         nx = x;
         ny = y;
         if (panel_cfg.rotation_mask[MaskReflectX]) nx = mirror(panel_cfg.panel_width, nx);
         if (panel_cfg.rotation_mask[MaskReflectY]) ny = mirror(panel_cfg.panel_height, ny);
         case (panel_cfg.rotation_mask[3:0])
            ROT_90: begin
               p.x = ny;
               p.y = mirror(panel_cfg.panel_width, nx);
            end
            ROT_180: begin
               p.x = mirror(panel_cfg.panel_width, nx);
               p.y = mirror(panel_cfg.panel_height, ny);
            end
            ROT_270: begin
               p.x = mirror(panel_cfg.panel_height, ny);
               p.y = nx;
            end
            default: begin
               p.x = nx;
               p.y = ny;
            end
         endcase
      end
      return p;
   endfunction

   task automatic compute_touch_result(input tpw_req_type r);
      tpw_rsp_type   rsp;
      tpw_point_type p0, p1;
      bit            a0, a1;
      rsp = '0;
      if (r.op == OP_TICK) begin
         if (release_ticks_left == 0) return;
         release_ticks_left = release_ticks_left - 1'b1;
         if (release_ticks_left != 0) return;
         held_finger = 1'b0;
         rsp.release_all = 1'b1;
         due_touch_results.push_back(rsp);
         return;
      end
      p0 = transform_point(r.first_slot, r.first_state, r.first_x, r.first_y, a0);
      p1 = transform_point(r.second_slot, r.second_state, r.second_x, r.second_y, a1);
      rsp.first_reported  = p0.reported;
      rsp.first_out_slot  = p0.slot;
      rsp.first_active    = p0.active;
      rsp.first_out_x     = p0.x;
      rsp.first_out_y     = p0.y;
      rsp.second_reported = p1.reported;
      rsp.second_out_slot = p1.slot;
      rsp.second_active   = p1.active;
      rsp.second_out_x    = p1.x;
      rsp.second_out_y    = p1.y;
      rsp.wake_request    = (a0 || a1) && panel_cfg.wake_allowed;
      if (a0 || a1) begin
         held_finger = 1'b1;
         release_ticks_left = (panel_cfg.watchdog_ticks != 0) ? panel_cfg.watchdog_ticks : 24'd1;
      end else if (held_finger) begin
         held_finger = 1'b0;
         release_ticks_left = '0;
      end
      due_touch_results.push_back(rsp);
   endtask

   function automatic logic [CoordWidth-1:0] random_coord();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return CoordWidth'($urandom);
   endfunction

   function automatic logic [SlotWidth-1:0] random_slot();
      if ($urandom_range(0, 99) < 80) return SlotWidth'($urandom_range(0, SlotCount - 1));
      return SlotWidth'($urandom_range(0, 15));
   endfunction

   function automatic logic [1:0] random_state();
      if ($urandom_range(0, 1)) return POINT_ACTIVE;
      return 2'($urandom_range(0, 3));
   endfunction

   function automatic tpw_req_type random_touch_request();
      tpw_req_type r;
      r.op           = ($urandom_range(0, 99) < 35) ? OP_TICK : OP_REPORT;
      r.first_slot   = random_slot();
      r.first_state  = random_state();
      r.first_x      = random_coord();
      r.first_y      = random_coord();
      r.second_slot  = random_slot();
      r.second_state = random_state();
      r.second_x     = random_coord();
      r.second_y     = random_coord();
      return r;
   endfunction

   function automatic tpw_req_type make_report(input logic [SlotWidth-1:0] s0,
                                               input logic [1:0] st0,
                                               input logic [CoordWidth-1:0] x0, y0,
                                               input logic [SlotWidth-1:0] s1,
                                               input logic [1:0] st1,
                                               input logic [CoordWidth-1:0] x1, y1);
      tpw_req_type r;
      r = '{OP_REPORT, s0, st0, x0, y0, s1, st1, x1, y1};
      return r;
   endfunction

   function automatic tpw_req_type make_tick();
      tpw_req_type r;
      r = random_touch_request();
      r.op = OP_TICK;
      return r;
   endfunction

   function automatic logic [CoordWidth-1:0] random_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'd1;
      if (r < 20) return 16'hFFFF;
      if (r < 25) return 16'd0;
      if (r < 45) return PANEL_WIDTH_RESET;
      return CoordWidth'($urandom_range(1, 65535));
   endfunction

   function automatic tpw_cfg_type random_panel_cfg();
      tpw_cfg_type c;
      logic [3:0]  rot;
      int unsigned r;
      c.panel_width       = random_size();
      c.panel_height      = random_size();
      c.swap_axes         = 1'($urandom_range(0, 1));
      c.invert_horizontal = 1'($urandom_range(0, 1));
      c.invert_vertical   = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
         0: rot = ROT_90;
         1: rot = ROT_180;
         2: rot = ROT_270;
         3: rot = ROT_0;
         default: rot = ROT_NONE;
      endcase
      if ($urandom_range(0, 1)) c.rotation_mask = {2'($urandom_range(0, 3)), rot};
      else c.rotation_mask = 6'($urandom_range(0, 63));
      r = $urandom_range(0, 99);
      if (r < 80) c.watchdog_ticks = TicksWidth'($urandom_range(1, 6));
      else if (r < 90) c.watchdog_ticks = '0;
      else c.watchdog_ticks = TicksWidth'($urandom_range(0, 24'hFFFFFF));
      c.wake_allowed = 1'($urandom_range(0, 1));
      return c;
   endfunction

   task automatic send_touch_request(input tpw_req_type item);
      int unsigned gap;
      gap = 0;
      if (req_gaps_on && $urandom_range(0, 99) < 30) gap = pick_gap();
      if (gap > 0) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= random_touch_request();
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      compute_touch_result(item);
   endtask

   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (due_touch_results.size() != 0) @(posedge clock);
      repeat (ResultLatency + 2) @(posedge clock);
   endtask

   task automatic write_register(input tpw_reg_type idx, input logic [CsrDataWidth-1:0] data);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= '{idx, data};
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         REG_PANEL_WIDTH:       panel_cfg.panel_width       = data[CoordWidth-1:0];
         REG_PANEL_HEIGHT:      panel_cfg.panel_height      = data[CoordWidth-1:0];
         REG_SWAP_AXES:         panel_cfg.swap_axes         = data[0];
         REG_INVERT_HORIZONTAL: panel_cfg.invert_horizontal = data[0];
         REG_INVERT_VERTICAL:   panel_cfg.invert_vertical   = data[0];
         REG_ROTATION_MASK:     panel_cfg.rotation_mask     = data[5:0];
         REG_WATCHDOG_TICKS:    panel_cfg.watchdog_ticks    = data[TicksWidth-1:0];
         default:               panel_cfg.wake_allowed      = data[0];
      endcase
   endtask

   task automatic apply_config(input tpw_cfg_type c);
      settle_block();
      write_register(REG_PANEL_WIDTH, CsrDataWidth'(c.panel_width));
      write_register(REG_PANEL_HEIGHT, CsrDataWidth'(c.panel_height));
      write_register(REG_SWAP_AXES, CsrDataWidth'(c.swap_axes));
      write_register(REG_INVERT_HORIZONTAL, CsrDataWidth'(c.invert_horizontal));
      write_register(REG_INVERT_VERTICAL, CsrDataWidth'(c.invert_vertical));
      write_register(REG_ROTATION_MASK, CsrDataWidth'(c.rotation_mask));
      write_register(REG_WATCHDOG_TICKS, CsrDataWidth'(c.watchdog_ticks));
      write_register(REG_WAKE_ALLOWED, CsrDataWidth'(c.wake_allowed));
      csr_if.valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_touch_request(make_report(4'd0, POINT_ACTIVE, 16'h0000, 16'hFFFF,
                                     4'd1, POINT_START, 16'hFFFF, 16'h0000));
      send_touch_request(make_tick());
      send_touch_request(make_report(4'd2, POINT_ACTIVE, 16'd100, 16'd200,
                                     4'd15, POINT_UNUSED, 16'hFFFF, 16'hFFFF));
      send_touch_request(make_tick());
      send_touch_request(make_report(4'd1, POINT_RELEASE, 16'd5, 16'd6,
                                     4'd0, POINT_ACTIVE, 16'd479, 16'd479));
   endtask

   task automatic test_rotation_codes();
      tpw_cfg_type c;
      logic [5:0]  masks [8];
      masks = '{{2'b00, ROT_NONE}, {2'b00, ROT_90}, {2'b00, ROT_180}, {2'b00, ROT_270},
                {2'b00, ROT_0 | ROT_90}, {2'b01, ROT_90}, {2'b10, ROT_270},
                {2'b11, ROT_0 | ROT_90 | ROT_180 | ROT_270}};
      for (int i = 0; i < 8; i++) begin
         c = '{16'd640, 16'd480, i[0], i[1], i[2], masks[i], 24'd5, i[0]};
         apply_config(c);
         send_touch_request(make_report(4'd0, POINT_ACTIVE, 16'd10, 16'd20,
                                        4'd1, POINT_ACTIVE, 16'd639, 16'd0));
      end
   endtask

   task automatic test_watchdog_expiry();
      tpw_cfg_type c;
      c = '{PANEL_WIDTH_RESET, PANEL_HEIGHT_RESET, 1'b0, 1'b0, 1'b0, ROTATION_MASK_RESET,
            24'd0, 1'b1};
      apply_config(c);
      send_touch_request(make_report(4'd1, POINT_ACTIVE, 16'd12, 16'd34,
                                     4'd0, POINT_RELEASE, 16'd0, 16'd0));
      send_touch_request(make_tick());
      c.watchdog_ticks = 24'd3;
      apply_config(c);
      send_touch_request(make_report(4'd0, POINT_ACTIVE, 16'd1, 16'd2,
                                     4'd3, POINT_ACTIVE, 16'd3, 16'd4));
      repeat (4) send_touch_request(make_tick());
   endtask

   task automatic test_coordinate_wrap();
      tpw_cfg_type c;
      c = '{16'd0, 16'd1, 1'b1, 1'b1, 1'b1, {2'b11, ROT_90}, 24'hFFFFFF, 1'b1};
      apply_config(c);
      send_touch_request(make_report(4'd0, POINT_ACTIVE, 16'h0000, 16'h0000,
                                     4'd1, POINT_ACTIVE, 16'hFFFF, 16'hFFFF));
      send_touch_request(make_report(4'd1, POINT_ACTIVE, 16'd1234, 16'hFFFF,
                                     4'd3, POINT_ACTIVE, 16'd1, 16'd1));
   endtask

   task automatic run_random_phase(input tpw_cfg_type c, input int unsigned item_total);
      int unsigned sent;
      int unsigned n;
      tpw_req_type r;
      apply_config(c);
      sent = 0;
      while (sent < item_total) begin
         if ($urandom_range(0, 99) < 75) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               r = random_touch_request();
               r.op = OP_REPORT;
               r.first_slot = SlotWidth'($urandom_range(0, SlotCount - 1));
               r.first_state = POINT_ACTIVE;
               send_touch_request(r);
               sent++;
            end
            if ($urandom_range(0, 1)) begin
               r = random_touch_request();
               r.op = OP_REPORT;
               r.first_state = $urandom_range(0, 1) ? POINT_RELEASE : POINT_START;
               r.second_state = $urandom_range(0, 1) ? POINT_UNUSED : POINT_RELEASE;
               send_touch_request(r);
               sent++;
            end else begin
               n = $urandom_range(1, 8);
               repeat (n) begin
                  send_touch_request(make_tick());
                  sent++;
               end
            end
         end else begin
            send_touch_request(random_touch_request());
            sent++;
         end
      end
   endtask

   task automatic test_random_phases();
      run_random_phase('{16'd1, 16'd1, 1'b0, 1'b0, 1'b0, 6'd0, 24'd1, 1'b0}, 65);
      run_random_phase('{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 6'h3F, 24'hFFFFFF, 1'b1}, 65);
      run_random_phase(random_panel_cfg(), 65);
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      run_random_phase(random_panel_cfg(), 65);
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      run_random_phase(random_panel_cfg(), 65);
      run_random_phase(random_panel_cfg(), 65);
   endtask

   task automatic test_backpressure();
      apply_config(random_panel_cfg());
      rsp_hold_off = 200;
      req_gaps_on = 1'b0;
      repeat (30) send_touch_request(random_touch_request());
      req_gaps_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      apply_config(random_panel_cfg());
      repeat (3) begin
         repeat (10) send_touch_request(random_touch_request());
         req_if.valid <= 1'b0;
         while (due_touch_results.size() != 0) @(posedge clock);
      end
   endtask

   initial begin
      rsp_if.ready   <= 1'b0;
      rsp_stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_off > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_off--;
         end else if (rsp_stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_gaps_on && $urandom_range(0, 99) < 20) rsp_stall_left = pick_gap();
         end
      end
   end

   function automatic void check_field(input string name, input int unsigned want_v,
                                       input int unsigned got_v);
      if (want_v != got_v) begin
         mismatch_count++;
         if (mismatch_count <= MismatchShown)
            $display("Mismatch on %0s: expected %0h, actual %0h", name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (due_touch_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MismatchShown)
               $display("Result with no request waiting: %h", rsp_if.payload);
         end else begin
            oldest_due = due_touch_results.pop_front();
            check_field("first_reported", oldest_due.first_reported,
                        rsp_if.payload.first_reported);
            check_field("first_out_slot", oldest_due.first_out_slot,
                        rsp_if.payload.first_out_slot);
            check_field("first_active", oldest_due.first_active, rsp_if.payload.first_active);
            check_field("first_out_x", oldest_due.first_out_x, rsp_if.payload.first_out_x);
            check_field("first_out_y", oldest_due.first_out_y, rsp_if.payload.first_out_y);
            check_field("second_reported", oldest_due.second_reported,
                        rsp_if.payload.second_reported);
            check_field("second_out_slot", oldest_due.second_out_slot,
                        rsp_if.payload.second_out_slot);
            check_field("second_active", oldest_due.second_active,
                        rsp_if.payload.second_active);
            check_field("second_out_x", oldest_due.second_out_x, rsp_if.payload.second_out_x);
            check_field("second_out_y", oldest_due.second_out_y, rsp_if.payload.second_out_y);
            check_field("release_all", oldest_due.release_all, rsp_if.payload.release_all);
            check_field("wake_request", oldest_due.wake_request, rsp_if.payload.wake_request);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      panel_cfg = '{PANEL_WIDTH_RESET, PANEL_HEIGHT_RESET, 1'b0, 1'b0, 1'b0,
                    ROTATION_MASK_RESET, WATCHDOG_TICKS_RESET, 1'b0};
      held_finger        = 1'b0;
      release_ticks_left = '0;
      mismatch_count     = 0;
      quiet_cycles       = 0;
      rsp_hold_off       = 0;
      req_gaps_on        = 1'b1;
      rsp_gaps_on        = 1'b1;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.payload <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_rotation_codes();
      test_watchdog_expiry();
      test_coordinate_wrap();
      test_random_phases();
      test_backpressure();
      test_sender_pause();
      settle_block();
      if (mismatch_count == 0 && due_touch_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
